>>> hw/rtl/pld_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pld_pkg
// Types, constants and helper functions for the planar lander dynamics block:
// fixed-point formats, angle range reduction and one CORDIC rotation step.
// ----------------------------------------------------------------------------
package pld_pkg;

  // Fraction bits of the external fixed-point format.
  localparam int FRAC_BITS     = 16;
  // Number of CORDIC rotation stages (at most 30).
  localparam int CORDIC_STAGES = 18;

  // Shift from the external format to Q30 angles.
  localparam int ANG_SHIFT = 30 - FRAC_BITS;
  // Width of a Q30 angle sum, with headroom for pi offsets.
  localparam int ANG_W_RAW = 24 + ANG_SHIFT;
  localparam int ANG_W     = (ANG_W_RAW > 36) ? ANG_W_RAW : 36;
  // Largest multiple of two pi that range reduction may remove.
  localparam int QMAX      = (1 << (22 - FRAC_BITS)) / 6 + 1;

  // CORDIC datapath width (Q30 plus sign and growth).
  localparam int CW = 33;
  // Gain times thrust fraction product width.
  localparam int PW = 48;
  // Trig product width.
  localparam int MW = 66;

  localparam longint Q30_PI_L     = 64'sd3373259426;
  localparam longint Q30_TWO_PI_L = 64'sd6746518852;
  localparam logic signed [ANG_W-1:0] Q30_PI      = ANG_W'(Q30_PI_L);
  localparam logic signed [ANG_W-1:0] Q30_HALF_PI = ANG_W'(64'sd1686629713);
  localparam logic signed [CW-1:0]    Q30_KGAIN   = CW'(64'sd652032874);

  localparam logic [PW-1:0] GAIN_HALF = PW'(64'd1) << (FRAC_BITS - 1);
  localparam logic signed [MW-1:0] TRIG_HALF = MW'(64'sd1) << 29;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_ACCEL_GAIN = 2'd0,
    REG_SPIN_GAIN  = 2'd1,
    REG_GRAVITY    = 2'd2
  } reg_idx_t;

  // Reduced angle and the flag that negates sine and cosine afterwards.
  typedef struct packed {
    logic signed [CW-1:0] r;
    logic                 neg;
  } red_t;

  // One CORDIC rotator's state.
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } rot_t;

  // Word carried through the rotation stages.
  typedef struct packed {
    rot_t                 ra;
    rot_t                 rg;
    logic                 neg_a;
    logic                 neg_g;
    logic [PW-1:0]        prod_t;
    logic [PW-1:0]        prod_s;
    logic signed [31:0]   xv;
    logic signed [31:0]   yv;
    logic signed [31:0]   pr;
  } pipe_t;

  // Word after the trig multipliers.
  typedef struct packed {
    logic signed [MW-1:0] m_sa;
    logic signed [MW-1:0] m_ca;
    logic signed [MW-1:0] m_sg;
    logic signed [31:0]   xv;
    logic signed [31:0]   yv;
    logic signed [31:0]   pr;
  } mul_t;

  // Truncated Q30 arctangent of two to the minus i.
  function automatic logic signed [CW-1:0] atan_q30(input int i);
    logic signed [CW-1:0] v;
    case (i)
      0:  v = CW'(64'sd843314856);
      1:  v = CW'(64'sd497837829);
      2:  v = CW'(64'sd263043836);
      3:  v = CW'(64'sd133525158);
      4:  v = CW'(64'sd67021686);
      5:  v = CW'(64'sd33543515);
      6:  v = CW'(64'sd16775850);
      7:  v = CW'(64'sd8388437);
      8:  v = CW'(64'sd4194282);
      9:  v = CW'(64'sd2097149);
      default: begin
        // Beyond stage nine the arctangent is two to the (30 - i), less one.
        v = (CW'(64'sd1) <<< (30 - i)) - CW'(64'sd1);
      end
    endcase
    return v;
  endfunction

  // Reduce a Q30 angle to [-pi/2, pi/2] and note whether a half turn was taken.
  function automatic red_t reduce(input logic signed [ANG_W-1:0] a);
    red_t                   res;
    logic signed [ANG_W-1:0] cand;
    logic signed [ANG_W-1:0] rr;
    rr = a;
    for (int k = -QMAX; k <= QMAX; k++) begin
      cand = a - ANG_W'(longint'(k) * Q30_TWO_PI_L);
      if ((cand >= -Q30_PI) && (cand < Q30_PI)) begin
        rr = cand;
      end
    end
    if (rr > Q30_HALF_PI) begin
      res.r   = CW'(rr - Q30_PI);
      res.neg = 1'b1;
    end else if (rr < -Q30_HALF_PI) begin
      res.r   = CW'(rr + Q30_PI);
      res.neg = 1'b1;
    end else begin
      res.r   = CW'(rr);
      res.neg = 1'b0;
    end
    return res;
  endfunction

  // One rotation-mode CORDIC step.
  function automatic rot_t cordic_step(input rot_t s, input int i);
    rot_t                 n;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    dx = s.y >>> i;
    dy = s.x >>> i;
    if (s.z >= 0) begin
      n.x = s.x - dx;
      n.y = s.y + dy;
      n.z = s.z - atan_q30(i);
    end else begin
      n.x = s.x + dx;
      n.y = s.y - dy;
      n.z = s.z + atan_q30(i);
    end
    return n;
  endfunction

  // Round a Q30 trig product to the external format.
  function automatic logic signed [MW-1:0] round_trig(input logic signed [MW-1:0] p);
    return (p + TRIG_HALF) >>> 30;
  endfunction

  // Saturate to a signed 32-bit word.
  function automatic logic signed [31:0] sat32(input logic signed [MW-1:0] v);
    logic signed [31:0] o;
    if (v > MW'(64'sd2147483647)) begin
      o = 32'sh7fffffff;
    end else if (v < -MW'(64'sd2147483648)) begin
      o = 32'sh80000000;
    end else begin
      o = 32'(v);
    end
    return o;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/planar_lander_dynamics.sv
`default_nettype none
// ----------------------------------------------------------------------------
// planar_lander_dynamics
// Time derivative of a planar gimballed-thrust lander, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (velocities, pitch, pitch rate, thrust fraction, gimbal) enter
//   on the in_valid/in_ready channel; one result word leaves on
//   out_valid/out_ready for each input word, in order.
//   Configuration writes (accel_gain, spin_gain, gravity) use cfg_valid/
//   cfg_ready with cfg_index and cfg_data; cfg_ready is always high and an
//   unknown index is ignored. Write only while the pipeline is empty.
//   The pipeline registers are, in order: range reduction and the gain
//   products, one per CORDIC rotation stage, the trig multipliers, and
//   rounding and saturation.
//   Throughput is one word per cycle while the receiver does not stall, set
//   by the one-stage-per-rotation CORDIC pipeline.
//   When the receiver stalls the whole pipeline holds and in_ready falls;
//   nothing is lost or repeated. Reset clears every stage's valid bit and
//   restores the configuration registers to their reset values.
// ----------------------------------------------------------------------------
module planar_lander_dynamics (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic signed [31:0]  x_vel,
  input  wire logic signed [31:0]  y_vel,
  input  wire logic signed [20:0]  pitch,
  input  wire logic signed [31:0]  pitch_rate,
  input  wire logic        [16:0]  thrust_fraction,
  input  wire logic signed [20:0]  gimbal_angle,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [31:0]       x_rate,
  output logic signed [31:0]       y_rate,
  output logic signed [31:0]       angle_rate,
  output logic signed [31:0]       x_accel,
  output logic signed [31:0]       y_accel,
  output logic signed [31:0]       angle_accel,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_data
);
  import pld_pkg::*;

  logic [30:0] accel_gain;
  logic [30:0] spin_gain;
  logic [30:0] gravity;

  logic  advance;
  pipe_t st  [0:CORDIC_STAGES];
  logic  vld [0:CORDIC_STAGES];
  mul_t  mw;
  logic  mvld;

  logic signed [ANG_W-1:0] ang_sum;
  logic signed [ANG_W-1:0] ang_gim;
  red_t                    red_a;
  red_t                    red_g;

  // The whole pipeline moves when the output word is free or being taken.
  assign advance   = !out_valid || out_ready;
  assign in_ready  = advance;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      accel_gain <= 31'd65536;
      spin_gain  <= 31'd65536;
      gravity    <= 31'd642908;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ACCEL_GAIN: accel_gain <= cfg_data[30:0];
        REG_SPIN_GAIN:  spin_gain  <= cfg_data[30:0];
        REG_GRAVITY:    gravity    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Angles to Q30 and range reduction.
  always_comb begin
    ang_sum = (ANG_W'(pitch) + ANG_W'(gimbal_angle)) <<< ANG_SHIFT;
    ang_gim = ANG_W'(gimbal_angle) <<< ANG_SHIFT;
    red_a   = reduce(ang_sum);
    red_g   = reduce(ang_gim);
  end

  // First stage: reduced angles, rotator start values and gain products.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (advance) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st[0].ra.x   <= Q30_KGAIN;
      st[0].ra.y   <= '0;
      st[0].ra.z   <= red_a.r;
      st[0].rg.x   <= Q30_KGAIN;
      st[0].rg.y   <= '0;
      st[0].rg.z   <= red_g.r;
      st[0].neg_a  <= red_a.neg;
      st[0].neg_g  <= red_g.neg;
      st[0].prod_t <= PW'(accel_gain) * PW'(thrust_fraction);
      st[0].prod_s <= PW'(spin_gain) * PW'(thrust_fraction);
      st[0].xv     <= x_vel;
      st[0].yv     <= y_vel;
      st[0].pr     <= pitch_rate;
    end
  end

  // CORDIC rotation stages, one rotation each.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (advance) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        st[i+1].ra     <= cordic_step(st[i].ra, i);
        st[i+1].rg     <= cordic_step(st[i].rg, i);
        st[i+1].neg_a  <= st[i].neg_a;
        st[i+1].neg_g  <= st[i].neg_g;
        st[i+1].prod_t <= st[i].prod_t;
        st[i+1].prod_s <= st[i].prod_s;
        st[i+1].xv     <= st[i].xv;
        st[i+1].yv     <= st[i].yv;
        st[i+1].pr     <= st[i].pr;
      end
    end
  end

  // Trig multipliers: rounded gains times signed sine and cosine.
  always_ff @(posedge clk) begin
    if (rst) begin
      mvld <= 1'b0;
    end else if (advance) begin
      mvld <= vld[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    logic [PW-1:0]        tr;
    logic [PW-1:0]        sr;
    logic signed [MW-1:0] t_s;
    logic signed [MW-1:0] s_s;
    logic signed [MW-1:0] sa;
    logic signed [MW-1:0] ca;
    logic signed [MW-1:0] sg;
    tr  = (st[CORDIC_STAGES].prod_t + GAIN_HALF) >> FRAC_BITS;
    sr  = (st[CORDIC_STAGES].prod_s + GAIN_HALF) >> FRAC_BITS;
    t_s = MW'(tr);
    s_s = MW'(sr);
    sa  = MW'(st[CORDIC_STAGES].ra.y);
    ca  = MW'(st[CORDIC_STAGES].ra.x);
    sg  = MW'(st[CORDIC_STAGES].rg.y);
    if (st[CORDIC_STAGES].neg_a) begin
      sa = -sa;
      ca = -ca;
    end
    if (st[CORDIC_STAGES].neg_g) begin
      sg = -sg;
    end
    if (advance) begin
      mw.m_sa <= t_s * sa;
      mw.m_ca <= t_s * ca;
      mw.m_sg <= s_s * sg;
      mw.xv   <= st[CORDIC_STAGES].xv;
      mw.yv   <= st[CORDIC_STAGES].yv;
      mw.pr   <= st[CORDIC_STAGES].pr;
    end
  end

  // Output stage: rounding, gravity and saturation.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= mvld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      x_rate      <= mw.xv;
      y_rate      <= mw.yv;
      angle_rate  <= mw.pr;
      x_accel     <= sat32(round_trig(mw.m_sa));
      y_accel     <= sat32(round_trig(mw.m_ca) - MW'(gravity));
      angle_accel <= sat32(-round_trig(mw.m_sg));
    end
  end

`ifndef SYNTHESIS
  // Nothing leaves the pipeline in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result word valid straight after reset");

  // A held pipeline keeps its valid bits.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(vld[0]) && $stable(mvld)))
    else $error("pipeline valid bits changed during a stall");

  // Range reduction leaves the rotator angle within a quarter turn.
  a_reduced: assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> ((st[0].ra.z <= CW'(Q30_HALF_PI)) && (st[0].ra.z >= -CW'(Q30_HALF_PI))))
    else $error("reduced angle out of range");
`endif

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Planar lander dynamics testbench
// Drives state samples through the block with bursty input and a stalling
// receiver, predicts each result word with a fixed-point model of its own and
// checks every field in order. The gain and gravity registers are changed
// between phases, including their extremes.
// ----------------------------------------------------------------------------
module tb_top;
  import pld_pkg::*;

  // One input sample as driven on the ports.
  typedef struct {
    logic signed [31:0] xv;
    logic signed [31:0] yv;
    logic signed [20:0] pa;
    logic signed [31:0] pr;
    logic [16:0]        thr;
    logic signed [20:0] gim;
  } sample_t;

  // One result word.
  typedef struct {
    logic signed [31:0] f[6];
  } deriv_t;

  // Scoreboard: predicts derivative words and compares arrivals in order.
  class deriv_board;
    deriv_t pending[$];
    longint acc_gain, spin_gain, grav;
    int     errors;

    function new();
      acc_gain  = 65536;
      spin_gain = 65536;
      grav      = 642908;
      errors    = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_ACCEL_GAIN: acc_gain  = longint'(val & 32'h7fffffff);
        REG_SPIN_GAIN:  spin_gain = longint'(val & 32'h7fffffff);
        REG_GRAVITY:    grav      = longint'(val & 32'h7fffffff);
        default: ;
      endcase
    endfunction

    // Floor shift that holds for negative operands.
    function longint floor_shr(longint v, int sh);
      return v >>> sh;
    endfunction

    // Range reduction followed by rotation-mode CORDIC, both in Q30.
    function void sin_cos(longint ang, output longint sn, output longint cs);
      longint two_pi, half_pi, pi_q, num, q, r, x, y, z, dx, dy, at;
      logic   flip;
      pi_q    = 64'sd3373259426;
      half_pi = 64'sd1686629713;
      two_pi  = 64'sd6746518852;
      num = ang + pi_q;
      q = num / two_pi;
      if (num - q * two_pi < 0) q = q - 1;
      r = ang - q * two_pi;
      flip = 1'b0;
      if (r > half_pi) begin
        r = r - pi_q;
        flip = 1'b1;
      end else if (r < -half_pi) begin
        r = r + pi_q;
        flip = 1'b1;
      end
      x = 64'sd652032874;
      y = 0;
      z = r;
      for (int i = 0; i < CORDIC_STAGES && i < 30; i++) begin
        case (i)
          0: at = 843314856;
          1: at = 497837829;
          2: at = 263043836;
          3: at = 133525158;
          4: at = 67021686;
          5: at = 33543515;
          6: at = 16775850;
          7: at = 8388437;
          8: at = 4194282;
          9: at = 2097149;
          default: at = (64'sd1 <<< (30 - i)) - 1;
        endcase
        dx = floor_shr(y, i);
        dy = floor_shr(x, i);
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - at;
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + at;
        end
      end
      sn = flip ? -y : y;
      cs = flip ? -x : x;
    endfunction

    function logic signed [31:0] clip(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return 32'(v);
    endfunction

    // Q30 trig product rounded half up. The products stay within 64 bits.
    function longint scale_trig(longint g, longint trig);
      return floor_shr(g * trig + (64'sd1 <<< 29), 30);
    endfunction

    function void note_sample(sample_t s);
      deriv_t d;
      longint pa, gm, t, sp, sa, ca, sg, cg;
      pa = longint'(s.pa) <<< (30 - FRAC_BITS);
      gm = longint'(s.gim) <<< (30 - FRAC_BITS);
      t  = (acc_gain * longint'(s.thr) + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      sp = (spin_gain * longint'(s.thr) + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      sin_cos(pa + gm, sa, ca);
      sin_cos(gm, sg, cg);
      d.f[0] = s.xv;
      d.f[1] = s.yv;
      d.f[2] = s.pr;
      d.f[3] = clip(scale_trig(t, sa));
      d.f[4] = clip(scale_trig(t, ca) - grav);
      d.f[5] = clip(-scale_trig(sp, sg));
      pending.push_back(d);
    endfunction

    function void check_word(deriv_t got);
      deriv_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: result word with none expected", $time);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      for (int k = 0; k < 6; k++) begin
        if (got.f[k] !== exp_w.f[k]) begin
          $display("%0t: field %0d expected %0d actual %0d",
                   $time, k, exp_w.f[k], got.f[k]);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, out_ready = 1'b0, cfg_valid = 1'b0;
  logic signed [31:0] x_vel = '0, y_vel = '0, pitch_rate = '0;
  logic signed [20:0] pitch = '0, gimbal_angle = '0;
  logic [16:0] thrust_fraction = '0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_ready, out_valid, cfg_ready;
  logic signed [31:0] x_rate, y_rate, angle_rate, x_accel, y_accel, angle_accel;

  deriv_board board = new();
  longint cycles = 0;
  logic   stall_fast;

  planar_lander_dynamics uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .x_vel(x_vel), .y_vel(y_vel), .pitch(pitch), .pitch_rate(pitch_rate),
    .thrust_fraction(thrust_fraction), .gimbal_angle(gimbal_angle),
    .out_valid(out_valid), .out_ready(out_ready),
    .x_rate(x_rate), .y_rate(y_rate), .angle_rate(angle_rate),
    .x_accel(x_accel), .y_accel(y_accel), .angle_accel(angle_accel),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Check each accepted result word and count cycles towards the limit.
  always @(posedge clk) begin
    deriv_t got;
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      got.f[0] = x_rate;
      got.f[1] = y_rate;
      got.f[2] = angle_rate;
      got.f[3] = x_accel;
      got.f[4] = y_accel;
      got.f[5] = angle_accel;
      board.check_word(got);
    end
  end

  // The receiver stalls on a pattern of its own: long free stretches, then
  // spells of heavy back-pressure.
  always @(negedge clk) begin
    if (($urandom % 200) == 0) stall_fast = ~stall_fast;
    if (stall_fast) out_ready <= ($urandom % 4) == 0;
    else out_ready <= ($urandom % 16) != 0;
  end

  // Present one sample and hold it until it is accepted.
  task automatic send_sample(sample_t s);
    in_valid        <= 1'b1;
    x_vel           <= s.xv;
    y_vel           <= s.yv;
    pitch           <= s.pa;
    pitch_rate      <= s.pr;
    thrust_fraction <= s.thr;
    gimbal_angle    <= s.gim;
    do @(posedge clk); while (!in_ready);
    board.note_sample(s);
    @(negedge clk);
  endtask

  // Write one register; cfg_valid stays high for a following write.
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, val);
    @(negedge clk);
  endtask

  // Wait until every expected word has come back, then let the pipe drain.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (CORDIC_STAGES + 8) @(negedge clk);
  endtask

  function automatic sample_t rand_sample(logic wide_angles);
    sample_t s;
    s.xv  = $urandom;
    s.yv  = $urandom;
    s.pr  = $urandom;
    s.thr = ($urandom % 8 == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
    if (wide_angles) begin
      s.pa  = 21'($urandom);
      s.gim = 21'($urandom);
    end else begin
      s.pa  = 21'($signed($urandom_range(0, 1647100)) - 823550);
      s.gim = 21'($signed($urandom_range(0, 1647100)) - 823550);
    end
    return s;
  endfunction

  // Random samples in bursts with random gaps.
  task automatic random_phase(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n > 0; k++, n--)
        send_sample(rand_sample(($urandom % 6) == 0));
      if ($urandom % 3 != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  endtask

  initial begin
    sample_t s;
    logic signed [20:0] angs[12];
    stall_fast = 1'b0;
    angs = '{0, 21'sd102944, -21'sd102944, 21'sd205887, -21'sd205887, 21'sd823550,
             -21'sd823550, 21'sd1048575, -21'sd1048576, 21'sd102943, 21'sd1, -21'sd1};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes, quarter turns, wide angles, thrust above one.
    for (int k = 0; k < 12; k++) begin
      s.xv  = (k % 2) ? 32'sh80000000 : 32'sh7fffffff;
      s.yv  = (k % 2) ? 32'sh7fffffff : 32'sh80000000;
      s.pr  = (k % 3 == 0) ? 32'shffffffff : 32'sh0;
      s.thr = (k % 4 == 0) ? 17'd0 : (k % 4 == 1) ? 17'd65536 : (k % 4 == 2) ?
              17'h1ffff : 17'd32768;
      s.pa  = angs[k];
      s.gim = angs[11 - k];
      send_sample(s);
    end
    random_phase(200);
    drain();

    // Extreme gains so that accelerations saturate both ways wherever their trig factor is not small.
    write_reg(REG_ACCEL_GAIN, 32'hffffffff);
    write_reg(REG_SPIN_GAIN, 32'h7fffffff);
    write_reg(REG_GRAVITY, 32'h0);
    cfg_valid <= 1'b0;
    for (int k = 0; k < 8; k++) begin
      s = rand_sample(1'b0);
      s.thr = 17'h1ffff;
      s.pa  = angs[k];
      s.gim = angs[k + 2];
      send_sample(s);
    end
    random_phase(400);
    drain();

    write_reg(REG_ACCEL_GAIN, 32'h0);
    write_reg(REG_SPIN_GAIN, 32'h0);
    write_reg(REG_GRAVITY, 32'h7fffffff);
    cfg_valid <= 1'b0;
    random_phase(150);
    drain();

    // Moderate random settings.
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_ACCEL_GAIN, $urandom_range(0, 32'h00200000));
      write_reg(REG_SPIN_GAIN, $urandom);
      write_reg(REG_GRAVITY, $urandom);
      cfg_valid <= 1'b0;
      random_phase(250);
      drain();
    end

    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
